[hdl/pts_pkg.sv]
`timescale 1ns / 1ps
// Package for the periodic task scheduler table: slot count, request codes,
// transfer payload types and the internal command format.
// No dependencies.
package pts_pkg;

    // Table size; slot_number is five bits wide, room for every slot index and SLOT_NONE.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int NUM_W  = 5;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;

    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_DELETE   = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_DISPATCH = 2'd3;

    localparam logic [NUM_W-1:0] SLOT_NONE  = NUM_W'(SLOTS);
    localparam logic [7:0]       SLOT_LIMIT = 8'(SLOTS);
    localparam logic [7:0]       PEND_MAX   = 8'd255;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] task_handle;
        logic [31:0] first_delay;
        logic [31:0] run_period;
        logic [7:0]  target_slot;
    } in_item_t;

    typedef struct packed {
        logic [NUM_W-1:0] slot_number;
        logic [31:0]      handle_out;
        logic             success;
        logic             run_valid;
        logic             last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_ADD_REJECT,
        OP_DELETE,
        OP_DELETE_BAD,
        OP_TICK,
        OP_DISPATCH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [31:0]       handle;
        logic [31:0]       delay;
        logic [31:0]       period;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

endpackage

[hdl/pts_front.sv]
`timescale 1ns / 1ps
// Front end of the scheduler table: accepts requests and classifies them
// into commands for the back end. Depends on pts_pkg.
module pts_front (
    input  logic             in_valid,
    output logic             in_stall,
    input  pts_pkg::in_item_t in_data,
    output logic             push,
    output pts_pkg::cmd_t    push_cmd,
    input  logic             queue_full
);
    import pts_pkg::*;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Reject zero handles and out-of-range delete targets up front.
    always_comb
    begin
        push_cmd.handle = in_data.task_handle;
        push_cmd.delay  = in_data.first_delay;
        push_cmd.period = in_data.run_period;
        push_cmd.slot   = in_data.target_slot[SLOT_W-1:0];
        case (in_data.req_type)
            REQ_ADD:
                push_cmd.op = (in_data.task_handle != 32'd0) ? OP_ADD : OP_ADD_REJECT;
            REQ_DELETE:
                push_cmd.op = (in_data.target_slot < SLOT_LIMIT) ? OP_DELETE : OP_DELETE_BAD;
            REQ_TICK:
                push_cmd.op = OP_TICK;
            REQ_DISPATCH:
                push_cmd.op = OP_DISPATCH;
            default:
                push_cmd.op = OP_TICK;
        endcase
    end

endmodule

[hdl/pts_cmd_queue.sv]
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the back end.
// Depends on pts_pkg.
module pts_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pts_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output pts_pkg::cmd_t pop_cmd
);
    import pts_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/pts_back.sv]
`timescale 1ns / 1ps
// Back end of the scheduler table: slot tables, sequencer over the slots
// and the result output register. Depends on pts_pkg.
module pts_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  pts_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output pts_pkg::out_item_t out_data
);
    import pts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DISP,
        ST_RESULT
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Slot tables; occ_reg marks which entries hold a live task.
    logic [31:0] handle_reg [SLOTS];
    logic [31:0] delay_reg  [SLOTS];
    logic [31:0] period_reg [SLOTS];
    logic [7:0]  pend_reg   [SLOTS];

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic [SLOTS-1:0]  occ_reg;
    logic [SLOTS-1:0]  occ_next;
    logic [SLOTS-1:0]  rdy_reg;
    logic [SLOTS-1:0]  rdy_next;
    out_item_t         res_reg;
    out_item_t         res_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;

    logic              out_free;
    logic [SLOT_W-1:0] free_idx;
    logic              free_found;
    logic              rdy_above;
    logic [31:0]       rd_handle;
    logic [31:0]       rd_delay;
    logic [31:0]       rd_period;
    logic [7:0]        rd_pend;
    logic              wr_all;
    logic              wr_dp;
    logic [SLOT_W-1:0] wr_idx;
    logic [31:0]       wr_delay;
    logic [7:0]        wr_pend;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign rd_handle = handle_reg[idx_reg];
    assign rd_delay  = delay_reg[idx_reg];
    assign rd_period = period_reg[idx_reg];
    assign rd_pend   = pend_reg[idx_reg];

    assign free_found = !(&occ_reg);
    assign rdy_above  = |((rdy_reg >> idx_reg) >> 1);

    // Lowest free slot.
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        occ_next       = occ_reg;
        rdy_next       = rdy_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        wr_all         = 1'b0;
        wr_dp          = 1'b0;
        wr_idx         = idx_reg;
        wr_delay       = rd_delay;
        wr_pend        = rd_pend;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ST_RESULT;
                    res_next   = '{slot_number: SLOT_NONE, handle_out: 32'd0,
                                   success: 1'b0, run_valid: 1'b0, last: 1'b1};
                    case (cmd.op)
                        OP_ADD:
                        begin
                            if (free_found)
                            begin
                                wr_all               = 1'b1;
                                wr_idx               = free_idx;
                                occ_next[free_idx]   = 1'b1;
                                rdy_next[free_idx]   = 1'b0;
                                res_next.slot_number = NUM_W'(free_idx);
                                res_next.success     = 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (occ_reg[cmd.slot])
                            begin
                                occ_next[cmd.slot]   = 1'b0;
                                rdy_next[cmd.slot]   = 1'b0;
                                res_next.slot_number = NUM_W'(cmd.slot);
                                res_next.success     = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        OP_DISPATCH:
                        begin
                            if (rdy_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = ST_DISP;
                            end
                        end
                        default:
                        begin
                            // Rejected add or bad delete: keep the failure result.
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (occ_reg[idx_reg])
                begin
                    wr_dp = 1'b1;
                    if (rd_delay == 32'd0)
                    begin
                        wr_delay          = rd_period;
                        wr_pend           = (rd_pend == PEND_MAX) ? rd_pend : rd_pend + 8'd1;
                        rdy_next[idx_reg] = 1'b1;
                    end
                    else
                    begin
                        wr_delay = rd_delay - 32'd1;
                    end
                end
                if (idx_reg == LAST_SLOT)
                begin
                    res_next   = '{slot_number: SLOT_NONE, handle_out: 32'd0,
                                   success: 1'b1, run_valid: 1'b0, last: 1'b1};
                    state_next = ST_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DISP:
            begin
                if (!rdy_reg[idx_reg])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{slot_number: NUM_W'(idx_reg), handle_out: rd_handle,
                                       success: 1'b1, run_valid: 1'b1, last: !rdy_above};
                    wr_dp          = 1'b1;
                    wr_pend        = rd_pend - 8'd1;
                    if (rd_period == 32'd0)
                    begin
                        occ_next[idx_reg] = 1'b0;
                        rdy_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        rdy_next[idx_reg] = (wr_pend != 8'd0);
                    end
                    if (rdy_above)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            occ_reg       <= '0;
            rdy_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            occ_reg       <= occ_next;
            rdy_reg       <= rdy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // Entries are only read while occ_reg marks them live.
    always_ff @(posedge clk)
    begin
        if (wr_all)
        begin
            handle_reg[wr_idx] <= cmd.handle;
            delay_reg[wr_idx]  <= cmd.delay;
            period_reg[wr_idx] <= cmd.period;
            pend_reg[wr_idx]   <= 8'd0;
        end
        else if (wr_dp)
        begin
            delay_reg[wr_idx] <= wr_delay;
            pend_reg[wr_idx]  <= wr_pend;
        end
    end

endmodule

[hdl/periodic_task_scheduler_table.sv]
`timescale 1ns / 1ps
// Top level of the periodic task scheduler table: front end, command queue
// and back end. Depends on pts_pkg, pts_front, pts_cmd_queue and pts_back.
//
//  channel | handshake          | payload            | transfers per request
//  --------+--------------------+--------------------+----------------------
//  in      | in_valid/in_stall  | in_data (in_item_t)| one
//  out     | out_valid/out_stall| out_data           | one, or one per ready slot
//
// Sequence: add, delete and an empty dispatch pop the command, then emit a
// result; tick pops, visits every slot in turn, then emits a result; a
// dispatch with ready slots pops, then walks the slots up to the last ready one,
// each result leaving as soon as the output register is free.
// Reset clears occupancy, ready bits, sequencer, queue and output valid flag.
// An output stall holds results; the queue fills, then in_stall rises.
module periodic_task_scheduler_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pts_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pts_pkg::out_item_t out_data
);
    import pts_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    // Classify each request transfer and drop it into the queue.
    pts_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    // Hold commands while the back end walks the table.
    pts_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    // Carry out each command against the slot tables and emit results.
    pts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
